// ===== design/pcr_pkg.sv =====
// Shared types, widths and helpers for the pairwise collision resolver.
package pcr_pkg;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam logic [15:0] COEF_RESET = 16'd16384;

	localparam int POS_W   = 32;
	localparam int RAD_W   = 24;
	localparam int COEF_W  = 16;
	localparam int DIFF_W  = 33;
	localparam int RS_W    = 25;
	localparam int MA_W    = 26;
	localparam int MB_W    = 25;
	localparam int PROD_W  = 51;
	localparam int ROOT_W  = 26;
	localparam int T_W     = 26;
	localparam int IDX_W   = 6;
	localparam int SQRT_STEPS = 26;
	localparam int DIV_STEPS  = PROD_W;

	localparam logic [2:0] JOB_AI  = 3'd0;
	localparam logic [2:0] JOB_AJ  = 3'd1;
	localparam logic [2:0] JOB_PIX = 3'd2;
	localparam logic [2:0] JOB_PIY = 3'd3;
	localparam logic [2:0] JOB_PJX = 3'd4;
	localparam logic [2:0] JOB_PJY = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PINIT, ST_RD, ST_DIFF, ST_CHK, ST_SQ2, ST_SQ3, ST_CMP,
		ST_SQW, ST_TM, ST_TT, ST_MDM, ST_MDD, ST_MDW, ST_WI, ST_WJ,
		ST_NEXT, ST_ERD, ST_EOUT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_READ_PAIR, OP_DIFF, OP_MUL_AX, OP_MUL_AY,
		OP_MUL_RS, OP_SQRT_GO, OP_MUL_T, OP_TAKE_T, OP_MD_MUL, OP_MD_DIV,
		OP_MD_TAKE, OP_WR_I, OP_WR_J, OP_READ_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] job;
	} dp_cmd_t;

	typedef struct packed {
		logic skip_a;
		logic skip_b;
		logic sqrt_busy;
		logic div_busy;
	} dp_stat_t;

	function automatic logic [POS_W-1:0] sat32(input logic signed [POS_W+1:0] v);
		logic [POS_W-1:0] r;
		if (v > $signed({3'b000, {(POS_W-1){1'b1}}}))
			r = {1'b0, {(POS_W-1){1'b1}}};
		else if (v < $signed({3'b111, {(POS_W-1){1'b0}}}))
			r = {1'b1, {(POS_W-1){1'b0}}};
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

endpackage

// ===== design/pcr_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module pcr_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pcr_pkg::PROD_W-1:0]   din,
	output logic                         busy,
	output logic [pcr_pkg::ROOT_W-1:0]   root
);
	localparam int W = pcr_pkg::PROD_W + 1;

	logic [W-1:0] v_q, res_q, bit_q;
	logic [4:0]   cnt_q;
	logic         busy_q;
	logic [W-1:0] trial;
	logic         ge;

	assign trial = res_q + bit_q;
	assign ge    = v_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(pcr_pkg::SQRT_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= {1'b0, din};
			res_q <= '0;
			bit_q <= W'(1) << (2 * (pcr_pkg::SQRT_STEPS - 1));
		end else if (busy_q) begin
			if (ge) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[pcr_pkg::ROOT_W-1:0];
endmodule

// ===== design/pcr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pcr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pcr_pkg::PROD_W-1:0]  dividend,
	input  logic [pcr_pkg::RS_W-1:0]    divisor,
	output logic                        busy,
	output logic [pcr_pkg::PROD_W-1:0]  quot
);
	localparam int N  = pcr_pkg::PROD_W;
	localparam int DW = pcr_pkg::RS_W;

	logic [N-1:0]  dvd_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   rem_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [DW:0]   r2;
	logic          ge;

	assign r2 = {rem_q[DW-1:0], dvd_q[N-1]};
	assign ge = r2 >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(pcr_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (r2 - {1'b0, div_q}) : r2;
			dvd_q <= {dvd_q[N-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = dvd_q;
endmodule

// ===== design/pcr_datapath.sv =====
// Particle stores, shared multiplier, root and divide units, position update.
module pcr_datapath #(
	parameter  int MAX_PARTICLES = pcr_pkg::MAX_PARTICLES_DEF,
	localparam int AW = $clog2(MAX_PARTICLES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pcr_pkg::dp_cmd_t            cmd,
	output pcr_pkg::dp_stat_t           stat,
	input  logic                        cfg_we,
	input  logic [pcr_pkg::COEF_W-1:0]  cfg_data,
	input  logic [AW-1:0]               addr_a,
	input  logic [AW-1:0]               addr_b,
	input  logic [pcr_pkg::POS_W-1:0]   pos_x,
	input  logic [pcr_pkg::POS_W-1:0]   pos_y,
	input  logic [pcr_pkg::RAD_W-1:0]   radius,
	output logic [pcr_pkg::POS_W-1:0]   out_x,
	output logic [pcr_pkg::POS_W-1:0]   out_y
);
	localparam int PW = pcr_pkg::POS_W;

	logic [PW-1:0] x_mem [MAX_PARTICLES];
	logic [PW-1:0] y_mem [MAX_PARTICLES];
	logic [pcr_pkg::RAD_W-1:0] r_mem [MAX_PARTICLES];

	logic [PW-1:0] xa_q, ya_q, xb_q, yb_q;
	logic [pcr_pkg::RAD_W-1:0] ra_q, rb_q;
	logic [pcr_pkg::COEF_W-1:0] coef_q;

	logic signed [pcr_pkg::DIFF_W-1:0] dx_q, dy_q;
	logic [pcr_pkg::RS_W-1:0]  rsum_q;
	logic [pcr_pkg::DIFF_W-1:0] adx, ady;
	logic [pcr_pkg::PROD_W-1:0] prod_q, dsq_q;
	logic [pcr_pkg::MA_W-1:0] mul_a;
	logic [pcr_pkg::MB_W-1:0] mul_b;
	logic [pcr_pkg::T_W-1:0] t_q, ai_q, aj_q, pix_q, piy_q, pjx_q, pjy_q;

	logic [pcr_pkg::ROOT_W-1:0] root;
	logic [pcr_pkg::PROD_W-1:0] quot;
	logic sqrt_busy, div_busy;
	logic [pcr_pkg::RS_W-1:0] divisor;

	logic we;
	logic [AW-1:0] wa;
	logic [PW-1:0] wx, wy;
	logic [PW-1:0] nxi, nyi, nxj, nyj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			coef_q <= pcr_pkg::COEF_RESET;
		else if (cfg_we)
			coef_q <= cfg_data;
	end

	// new positions: i adds its push, j subtracts its own
	always_comb begin
		logic signed [PW+1:0] sx, sy, ex, ey;
		sx = dx_q[pcr_pkg::DIFF_W-1] ? -$signed({8'd0, pix_q}) : $signed({8'd0, pix_q});
		sy = dy_q[pcr_pkg::DIFF_W-1] ? -$signed({8'd0, piy_q}) : $signed({8'd0, piy_q});
		ex = dx_q[pcr_pkg::DIFF_W-1] ? -$signed({8'd0, pjx_q}) : $signed({8'd0, pjx_q});
		ey = dy_q[pcr_pkg::DIFF_W-1] ? -$signed({8'd0, pjy_q}) : $signed({8'd0, pjy_q});
		nxi = pcr_pkg::sat32($signed({{2{xa_q[PW-1]}}, xa_q}) + sx);
		nyi = pcr_pkg::sat32($signed({{2{ya_q[PW-1]}}, ya_q}) + sy);
		nxj = pcr_pkg::sat32($signed({{2{xb_q[PW-1]}}, xb_q}) - ex);
		nyj = pcr_pkg::sat32($signed({{2{yb_q[PW-1]}}, yb_q}) - ey);
	end

	always_comb begin
		we = 1'b0;
		wa = addr_a;
		wx = pos_x;
		wy = pos_y;
		unique case (cmd.op)
			pcr_pkg::OP_LOAD: we = 1'b1;
			pcr_pkg::OP_WR_I: begin
				we = 1'b1;
				wx = nxi;
				wy = nyi;
			end
			pcr_pkg::OP_WR_J: begin
				we = 1'b1;
				wa = addr_b;
				wx = nxj;
				wy = nyj;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			x_mem[wa] <= wx;
			y_mem[wa] <= wy;
		end
		if (cmd.op == pcr_pkg::OP_LOAD)
			r_mem[addr_a] <= radius;
		if (cmd.op == pcr_pkg::OP_READ_PAIR || cmd.op == pcr_pkg::OP_READ_EMIT) begin
			xa_q <= x_mem[addr_a];
			ya_q <= y_mem[addr_a];
			ra_q <= r_mem[addr_a];
			xb_q <= x_mem[addr_b];
			yb_q <= y_mem[addr_b];
			rb_q <= r_mem[addr_b];
		end
	end

	assign adx = dx_q[pcr_pkg::DIFF_W-1] ? 33'(-dx_q) : 33'(dx_q);
	assign ady = dy_q[pcr_pkg::DIFF_W-1] ? 33'(-dy_q) : 33'(dy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			pcr_pkg::OP_MUL_AX: begin
				mul_a = {1'b0, adx[pcr_pkg::MB_W-1:0]};
				mul_b = adx[pcr_pkg::MB_W-1:0];
			end
			pcr_pkg::OP_MUL_AY: begin
				mul_a = {1'b0, ady[pcr_pkg::MB_W-1:0]};
				mul_b = ady[pcr_pkg::MB_W-1:0];
			end
			pcr_pkg::OP_MUL_RS: begin
				mul_a = {1'b0, rsum_q};
				mul_b = rsum_q;
			end
			pcr_pkg::OP_MUL_T: begin
				mul_a = {10'd0, coef_q};
				mul_b = rsum_q - root[pcr_pkg::RS_W-1:0];
			end
			pcr_pkg::OP_MD_MUL: begin
				case (cmd.job)
					pcr_pkg::JOB_AI:  begin mul_a = t_q;  mul_b = {1'b0, rb_q}; end
					pcr_pkg::JOB_AJ:  begin mul_a = t_q;  mul_b = {1'b0, ra_q}; end
					pcr_pkg::JOB_PIX: begin mul_a = ai_q; mul_b = adx[pcr_pkg::MB_W-1:0]; end
					pcr_pkg::JOB_PIY: begin mul_a = ai_q; mul_b = ady[pcr_pkg::MB_W-1:0]; end
					pcr_pkg::JOB_PJX: begin mul_a = aj_q; mul_b = adx[pcr_pkg::MB_W-1:0]; end
					default:          begin mul_a = aj_q; mul_b = ady[pcr_pkg::MB_W-1:0]; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign divisor = (cmd.job == pcr_pkg::JOB_AI || cmd.job == pcr_pkg::JOB_AJ) ?
	                 rsum_q : root[pcr_pkg::RS_W-1:0];

	always_ff @(posedge clk) begin
		case (cmd.op)
			pcr_pkg::OP_DIFF: begin
				dx_q   <= $signed({xa_q[PW-1], xa_q}) - $signed({xb_q[PW-1], xb_q});
				dy_q   <= $signed({ya_q[PW-1], ya_q}) - $signed({yb_q[PW-1], yb_q});
				rsum_q <= {1'b0, ra_q} + {1'b0, rb_q};
			end
			pcr_pkg::OP_MUL_AX, pcr_pkg::OP_MUL_T, pcr_pkg::OP_MD_MUL:
				prod_q <= mul_a * mul_b;
			pcr_pkg::OP_MUL_AY: begin
				prod_q <= mul_a * mul_b;
				dsq_q  <= prod_q;
			end
			pcr_pkg::OP_MUL_RS: begin
				prod_q <= mul_a * mul_b;
				dsq_q  <= dsq_q + prod_q;
			end
			pcr_pkg::OP_TAKE_T: t_q <= prod_q[pcr_pkg::T_W+14:15];
			pcr_pkg::OP_MD_TAKE: begin
				case (cmd.job)
					pcr_pkg::JOB_AI:  ai_q  <= quot[pcr_pkg::T_W-1:0];
					pcr_pkg::JOB_AJ:  aj_q  <= quot[pcr_pkg::T_W-1:0];
					pcr_pkg::JOB_PIX: pix_q <= quot[pcr_pkg::T_W-1:0];
					pcr_pkg::JOB_PIY: piy_q <= quot[pcr_pkg::T_W-1:0];
					pcr_pkg::JOB_PJX: pjx_q <= quot[pcr_pkg::T_W-1:0];
					default:          pjy_q <= quot[pcr_pkg::T_W-1:0];
				endcase
			end
			default: ;
		endcase
	end

	pcr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == pcr_pkg::OP_SQRT_GO),
		.din    (dsq_q),
		.busy   (sqrt_busy),
		.root   (root)
	);

	pcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == pcr_pkg::OP_MD_DIV),
		.dividend (prod_q),
		.divisor  (divisor),
		.busy     (div_busy),
		.quot     (quot)
	);

	// coarse reject: zero radii, box test, coincident centres
	assign stat.skip_a = (rsum_q == '0) || (adx >= {8'd0, rsum_q}) ||
	                     (ady >= {8'd0, rsum_q}) || (adx == '0 && ady == '0);
	assign stat.skip_b    = dsq_q >= prod_q;
	assign stat.sqrt_busy = sqrt_busy;
	assign stat.div_busy  = div_busy;

	assign out_x = xa_q;
	assign out_y = ya_q;
endmodule

// ===== design/pcr_ctrl.sv =====
// Sequencer for loading, the pair pass and emission.
module pcr_ctrl #(
	parameter  int MAX_PARTICLES = pcr_pkg::MAX_PARTICLES_DEF,
	localparam int AW = $clog2(MAX_PARTICLES),
	localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        last_in,
	output logic                        busy,
	output pcr_pkg::dp_cmd_t            cmd,
	input  pcr_pkg::dp_stat_t           stat,
	output logic [AW-1:0]               addr_a,
	output logic [AW-1:0]               addr_b,
	output logic                        result_valid,
	output logic [pcr_pkg::IDX_W-1:0]   particle_index,
	output logic                        overflowed,
	output logic                        last_out
);
	pcr_pkg::ctrl_state_t state_q, state_d;

	logic [CW-1:0] count_q, i_q, j_q, k_q;
	logic [2:0]    job_q;
	logic          ovf_q;
	logic          room;
	logic          j_more, i_more, k_last;

	assign room   = count_q < CW'(MAX_PARTICLES);
	assign j_more = ({1'b0, j_q} + 1'b1) < {1'b0, count_q};
	assign i_more = ({1'b0, i_q} + 2'd2) < {1'b0, count_q};
	assign k_last = ({1'b0, k_q} + 1'b1) == {1'b0, count_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcr_pkg::ST_IDLE:  if (start && last_in) state_d = pcr_pkg::ST_PINIT;
			pcr_pkg::ST_PINIT: state_d = (count_q < CW'(2)) ? pcr_pkg::ST_ERD : pcr_pkg::ST_RD;
			pcr_pkg::ST_RD:    state_d = pcr_pkg::ST_DIFF;
			pcr_pkg::ST_DIFF:  state_d = pcr_pkg::ST_CHK;
			pcr_pkg::ST_CHK:   state_d = stat.skip_a ? pcr_pkg::ST_NEXT : pcr_pkg::ST_SQ2;
			pcr_pkg::ST_SQ2:   state_d = pcr_pkg::ST_SQ3;
			pcr_pkg::ST_SQ3:   state_d = pcr_pkg::ST_CMP;
			pcr_pkg::ST_CMP:   state_d = stat.skip_b ? pcr_pkg::ST_NEXT : pcr_pkg::ST_SQW;
			pcr_pkg::ST_SQW:   if (!stat.sqrt_busy) state_d = pcr_pkg::ST_TM;
			pcr_pkg::ST_TM:    state_d = pcr_pkg::ST_TT;
			pcr_pkg::ST_TT:    state_d = pcr_pkg::ST_MDM;
			pcr_pkg::ST_MDM:   state_d = pcr_pkg::ST_MDD;
			pcr_pkg::ST_MDD:   state_d = pcr_pkg::ST_MDW;
			pcr_pkg::ST_MDW: begin
				if (!stat.div_busy)
					state_d = (job_q == pcr_pkg::JOB_PJY) ? pcr_pkg::ST_WI : pcr_pkg::ST_MDM;
			end
			pcr_pkg::ST_WI:    state_d = pcr_pkg::ST_WJ;
			pcr_pkg::ST_WJ:    state_d = pcr_pkg::ST_NEXT;
			pcr_pkg::ST_NEXT:  state_d = (j_more || i_more) ? pcr_pkg::ST_RD : pcr_pkg::ST_ERD;
			pcr_pkg::ST_ERD:   state_d = pcr_pkg::ST_EOUT;
			pcr_pkg::ST_EOUT:  state_d = k_last ? pcr_pkg::ST_IDLE : pcr_pkg::ST_ERD;
			default:           state_d = pcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op  = pcr_pkg::OP_NONE;
		cmd.job = job_q;
		unique case (state_q)
			pcr_pkg::ST_IDLE: if (start && room) cmd.op = pcr_pkg::OP_LOAD;
			pcr_pkg::ST_RD:   cmd.op = pcr_pkg::OP_READ_PAIR;
			pcr_pkg::ST_DIFF: cmd.op = pcr_pkg::OP_DIFF;
			pcr_pkg::ST_CHK:  if (!stat.skip_a) cmd.op = pcr_pkg::OP_MUL_AX;
			pcr_pkg::ST_SQ2:  cmd.op = pcr_pkg::OP_MUL_AY;
			pcr_pkg::ST_SQ3:  cmd.op = pcr_pkg::OP_MUL_RS;
			pcr_pkg::ST_CMP:  if (!stat.skip_b) cmd.op = pcr_pkg::OP_SQRT_GO;
			pcr_pkg::ST_TM:   cmd.op = pcr_pkg::OP_MUL_T;
			pcr_pkg::ST_TT:   cmd.op = pcr_pkg::OP_TAKE_T;
			pcr_pkg::ST_MDM:  cmd.op = pcr_pkg::OP_MD_MUL;
			pcr_pkg::ST_MDD:  cmd.op = pcr_pkg::OP_MD_DIV;
			pcr_pkg::ST_MDW:  if (!stat.div_busy) cmd.op = pcr_pkg::OP_MD_TAKE;
			pcr_pkg::ST_WI:   cmd.op = pcr_pkg::OP_WR_I;
			pcr_pkg::ST_WJ:   cmd.op = pcr_pkg::OP_WR_J;
			pcr_pkg::ST_ERD:  cmd.op = pcr_pkg::OP_READ_EMIT;
			default:          cmd.op = pcr_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcr_pkg::ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			job_q   <= pcr_pkg::JOB_AI;
		end else begin
			state_q <= state_d;
			case (state_q)
				pcr_pkg::ST_IDLE: begin
					if (start) begin
						if (room)
							count_q <= count_q + 1'b1;
						else
							ovf_q <= 1'b1;
					end
				end
				pcr_pkg::ST_PINIT: begin
					i_q <= '0;
					j_q <= CW'(1);
					k_q <= '0;
				end
				pcr_pkg::ST_TT: job_q <= pcr_pkg::JOB_AI;
				pcr_pkg::ST_MDW: if (!stat.div_busy) job_q <= job_q + 3'd1;
				pcr_pkg::ST_NEXT: begin
					// advance j, or move to the next row of pairs
					if (j_more) begin
						j_q <= j_q + 1'b1;
					end else if (i_more) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + CW'(2);
					end
					k_q <= '0;
				end
				pcr_pkg::ST_EOUT: begin
					if (k_last) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy   = state_q != pcr_pkg::ST_IDLE;
	assign addr_a = (state_q == pcr_pkg::ST_IDLE) ? count_q[AW-1:0] :
	                (state_q == pcr_pkg::ST_ERD)  ? k_q[AW-1:0] : i_q[AW-1:0];
	assign addr_b = j_q[AW-1:0];

	assign result_valid   = state_q == pcr_pkg::ST_EOUT;
	assign particle_index = pcr_pkg::IDX_W'(k_q[AW-1:0]);
	assign overflowed     = ovf_q;
	assign last_out       = k_last;
endmodule

// ===== design/pairwise_collision_resolver_unit.sv =====
// Top level of the pairwise collision resolver.
// Usage:
//   Load a set of particles by pulsing start with pos_x, pos_y, radius while
//   busy is low, one request per cycle. last_in on a request ends the set and
//   starts the collision pass; busy then stays high until the set is emitted.
//   Requests beyond MAX_PARTICLES are dropped and flagged on overflowed.
//   Results: result_valid is high for one cycle per stored particle, in load
//   order, with out_x, out_y, particle_index, overflowed and last_out. The
//   receiver cannot stall; each result is taken in the cycle it is shown.
//   Pass: a pair that does not overlap is rejected at the box test or the
//   distance compare; an overlapping pair waits on the shared serial root
//   unit and makes six passes through the shared one-bit-per-cycle divider.
//   Emission reads each particle through the registered store read port
//   (ST_ERD) and shows it in ST_EOUT.
//   Configuration: write response_coef via cfg_valid/cfg_data; cfg_ready is
//   always high. Write only while busy is low.
//   Reset clears the set and restores response_coef to 0.5; store contents
//   are undefined until loaded.
module pairwise_collision_resolver_unit #(
	parameter int MAX_PARTICLES = pcr_pkg::MAX_PARTICLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [31:0]          pos_x,
	input  logic signed [31:0]          pos_y,
	input  logic [23:0]                 radius,
	input  logic                        last_in,
	output logic                        result_valid,
	output logic signed [31:0]          out_x,
	output logic signed [31:0]          out_y,
	output logic [5:0]                  particle_index,
	output logic                        overflowed,
	output logic                        last_out,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [15:0]                 cfg_data
);
	localparam int AW = $clog2(MAX_PARTICLES);

	pcr_pkg::dp_cmd_t  cmd;
	pcr_pkg::dp_stat_t stat;
	logic [AW-1:0] addr_a, addr_b;
	logic [31:0]   ox, oy;

	assign cfg_ready = 1'b1;

	pcr_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.last_in        (last_in),
		.busy           (busy),
		.cmd            (cmd),
		.stat           (stat),
		.addr_a         (addr_a),
		.addr_b         (addr_b),
		.result_valid   (result_valid),
		.particle_index (particle_index),
		.overflowed     (overflowed),
		.last_out       (last_out)
	);

	pcr_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.addr_a   (addr_a),
		.addr_b   (addr_b),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.radius   (radius),
		.out_x    (ox),
		.out_y    (oy)
	);

	assign out_x = $signed(ox);
	assign out_y = $signed(oy);
endmodule
